// ===== src/pli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;
  localparam int unsigned MaxPointsDefault = 256;
  localparam int unsigned FracBitsDefault  = 16;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic clear;      // reset point count
    logic append;     // write input point
    logic load_q;     // capture query, start scan
    logic scan_rd;    // issue read at scan index
    logic scan_upd;   // compare returned entry
    logic rd_n;       // read nearest entry
    logic sel_seg;    // compute segment ends
    logic rd_lo;      // read low segment end
    logic rd_hi;      // read high segment end
    logic prep;       // form operands
    logic mul;        // multiply step
    logic div_start;  // start divider
    logic div_step;   // one quotient bit
    logic finish;     // form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // last scan read issued
    logic few;        // fewer than two points
    logic dx_zero;    // zero-width segment
    logic div_done;   // divider finished
    logic mul_done;   // multiplier finished
  } sts_t;
endpackage
`default_nettype wire

// ===== src/pli_datapath.sv =====
// Datapath: breakpoint memories, scan, segment selection, multiply, serial divide.
// Depends on pli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pli_datapath import pli_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] query_x_i,
  output logic      [31:0] value_y_o,
  output logic      [7:0]  nearest_index_o,
  output logic      [1:0]  status_o
);
  localparam int unsigned AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CW = $clog2(MaxPoints + 1);

  logic [31:0] xmem [MaxPoints];
  logic [31:0] ymem [MaxPoints];
  logic [CW-1:0] count_q;
  logic [AW-1:0] raddr;
  logic [31:0] xr_q, yr_q;

  logic signed [31:0] q_q;
  logic [CW-1:0] idx_q;       // next scan address
  logic [AW-1:0] rd_idx_q;    // address of data in xr_q
  logic [AW-1:0] n_q, lo_q, hi_q;
  logic [32:0] best_q;
  logic best_vld_q;
  logic signed [31:0] xn_q, yn_q, xlo_q, ylo_q;
  logic [32:0] moff_q, mdy_q, mdx_q;
  logic neg_q, dxz_q;
  logic [65:0] prod_q;
  logic [5:0] mcnt_q;
  logic [65:0] rem_q;
  logic [65:0] quot_q;
  logic [6:0] dcnt_q;
  logic [31:0] val_q;
  logic [1:0] st_q;

  // memory read address
  always_comb begin
    raddr = idx_q[AW-1:0];
    if (cmd_i.rd_n) raddr = n_q;
    else if (cmd_i.rd_lo) raddr = lo_q;
    else if (cmd_i.rd_hi) raddr = hi_q;
  end

  // breakpoint storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && count_q < CW'(MaxPoints)) begin
      xmem[count_q[AW-1:0]] <= point_x_i;
      ymem[count_q[AW-1:0]] <= point_y_i;
    end
    xr_q <= xmem[raddr];
    yr_q <= ymem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.append && count_q < CW'(MaxPoints)) begin
      count_q <= count_q + 1'b1;
    end
  end

  // distance of current entry
  logic signed [32:0] diff;
  logic [32:0] abs_diff;
  assign diff = 33'(q_q) - 33'(signed'(xr_q));
  assign abs_diff = diff[32] ? 33'(-diff) : diff;

  // segment choice, xr_q holds entry n
  logic [CW-1:0] last;
  logic xgt;
  assign last = count_q - 1'b1;
  assign xgt  = $signed(xr_q) > q_q;

  // operand magnitudes
  logic signed [32:0] off_s, dy_s, dx_s;
  assign off_s = 33'(q_q) - 33'(xn_q);
  assign dy_s  = 33'(signed'(yr_q)) - 33'(ylo_q);
  assign dx_s  = 33'(signed'(xr_q)) - 33'(xlo_q);

  // restoring division step
  logic [66:0] trial;
  assign trial = {rem_q, quot_q[65]} - {34'd0, mdx_q};

  // final sum
  logic [34:0] qc;
  logic signed [36:0] sum;
  assign qc  = (quot_q > 66'(35'h4_0000_0000)) ? 35'h4_0000_0000 : quot_q[34:0];
  assign sum = (neg_q && qc != '0) ? 37'(yn_q) - 37'(qc) : 37'(yn_q) + 37'(qc);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_q) begin
      q_q <= query_x_i;
      idx_q <= '0;
      n_q <= '0;
      best_vld_q <= 1'b0;
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= idx_q[AW-1:0];
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.scan_upd) begin
      if (!best_vld_q || abs_diff <= best_q) begin
        best_q <= abs_diff;
        n_q <= rd_idx_q;
        best_vld_q <= 1'b1;
      end
    end
    if (cmd_i.sel_seg) begin
      // xr/yr hold entry n here
      xn_q <= xr_q;
      yn_q <= yr_q;
      if (xgt) begin
        lo_q <= (n_q != '0) ? n_q - 1'b1 : '0;
        hi_q <= (n_q != '0) ? n_q : AW'(1);
      end else begin
        lo_q <= (CW'(n_q) < last) ? n_q : n_q - 1'b1;
        hi_q <= (CW'(n_q) < last) ? n_q + 1'b1 : n_q;
      end
    end
    if (cmd_i.rd_hi) begin
      xlo_q <= xr_q;
      ylo_q <= yr_q;
    end
    if (cmd_i.prep) begin
      moff_q <= off_s[32] ? 33'(-off_s) : off_s;
      mdy_q  <= dy_s[32] ? 33'(-dy_s) : dy_s;
      mdx_q  <= dx_s[32] ? 33'(-dx_s) : dx_s;
      neg_q  <= (off_s[32] ^ dy_s[32]) ^ dx_s[32];
      dxz_q  <= (dx_s == '0);
      prod_q <= '0;
      mcnt_q <= '0;
    end
    // shift-add multiply, one bit a cycle, |dy| fits in 32 bits
    if (cmd_i.mul) begin
      prod_q <= {prod_q[64:0], 1'b0} + (mdy_q[31] ? 66'(moff_q) : 66'd0);
      mdy_q  <= {mdy_q[31:0], 1'b0};
      mcnt_q <= mcnt_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quot_q <= prod_q;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (!trial[66]) begin
        rem_q <= trial[65:0];
        quot_q <= {quot_q[64:0], 1'b1};
      end else begin
        rem_q <= {rem_q[64:0], quot_q[65]};
        quot_q <= {quot_q[64:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      if (count_q < CW'(2)) begin
        val_q <= '0;
        st_q <= ST_FEW;
      end else if (dxz_q) begin
        val_q <= yn_q;
        st_q <= ST_ZERO;
      end else if (sum > 37'sh0_7FFF_FFFF) begin
        val_q <= 32'h7FFF_FFFF;
        st_q <= ST_SAT;
      end else if (sum < -37'sh0_8000_0000) begin
        val_q <= 32'h8000_0000;
        st_q <= ST_SAT;
      end else begin
        val_q <= sum[31:0];
        st_q <= ST_OK;
      end
    end
  end

  assign sts_o.scan_last = (idx_q + 1'b1 >= count_q);
  assign sts_o.few       = (count_q < CW'(2));
  assign sts_o.dx_zero   = dxz_q;
  assign sts_o.mul_done  = (mcnt_q == 6'd32);
  assign sts_o.div_done  = (dcnt_q == 7'd66);

  assign value_y_o       = val_q;
  assign nearest_index_o = 8'(n_q);
  assign status_o        = st_q;
endmodule
`default_nettype wire

// ===== src/pli_ctrl.sv =====
// Controller state machine sequencing scan, segment reads, multiply and divide.
// Depends on pli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pli_ctrl import pli_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] func_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output cmd_t            cmd_o,
  input  wire sts_t       sts_i
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SCAN  = 12'b000000000010,
    S_DRAIN = 12'b000000000100,
    S_RDN   = 12'b000000001000,
    S_SEL   = 12'b000000010000,
    S_RDLO  = 12'b000000100000,
    S_RDHI  = 12'b000001000000,
    S_PREP  = 12'b000010000000,
    S_MUL   = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic acc;
  logic out_busy;
  logic scan_prev_q;  // a scan read was issued last cycle
  assign out_busy   = out_valid_o && !out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !out_busy;
  assign acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_o <= 1'b0;
      scan_prev_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_prev_q <= (state_q == S_SCAN);
      if (state_q == S_FIN) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (func_e'(func_i))
            FUNC_CLEAR:  cmd_o.clear = 1'b1;
            FUNC_APPEND: cmd_o.append = 1'b1;
            FUNC_QUERY: begin
              cmd_o.load_q = 1'b1;
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle while issuing the next read
        cmd_o.scan_upd = scan_prev_q;
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.scan_upd = 1'b1;
        state_d = sts_i.few ? S_FIN : S_RDN;
      end
      S_RDN: begin
        cmd_o.rd_n = 1'b1;
        state_d = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel_seg = 1'b1;
        state_d = S_RDLO;
      end
      S_RDLO: begin
        cmd_o.rd_lo = 1'b1;
        state_d = S_RDHI;
      end
      S_RDHI: begin
        cmd_o.rd_hi = 1'b1;
        state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (sts_i.mul_done) begin
          cmd_o.div_start = 1'b1;
          state_d = sts_i.dx_zero ? S_FIN : S_DIV;
        end else begin
          cmd_o.mul = 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_FIN;
        else cmd_o.div_step = 1'b1;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator.
// Depends on pli_pkg, pli_ctrl, pli_datapath.
//
// Input stream s_axis: tuser = func (clear, append, query); tdata = point_x,
// point_y, query_x. Output stream m_axis: tdata = value_y, nearest_index;
// tuser = status. Clear and append give no result. A query gives one item:
// a scan of N stored points (at least one read, through the registered
// memory read port), a drain step, the segment reads and operand setup, a
// 32-step shift-add multiply, a 66-step restoring divide and a final step
// that forms the result. No new item is taken before the query has finished
// and the controller is back in idle. A zero-width segment skips the divide;
// tables under two points skip the arithmetic. The output register holds its
// item until taken; while it is stalled no new item is accepted.
// Reset clears the point count and the controller; the tables need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // point_x, point_y, query_x
  input  wire logic [1:0]   s_axis_tuser,  // func
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [39:0]  m_axis_tdata,  // value_y, nearest_index
  output logic      [1:0]   m_axis_tuser   // status
);
  cmd_t cmd;
  sts_t sts;
  logic [31:0] value_y;
  logic [7:0]  nearest_index;
  logic [1:0]  status;

  pli_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pli_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .point_x_i      (s_axis_tdata[31:0]),
    .point_y_i      (s_axis_tdata[63:32]),
    .query_x_i      (s_axis_tdata[95:64]),
    .value_y_o      (value_y),
    .nearest_index_o(nearest_index),
    .status_o       (status)
  );

  assign m_axis_tdata = {nearest_index, value_y};
  assign m_axis_tuser = status;
endmodule
`default_nettype wire
